// File: hdl/mvdi_pkg.sv
// Shared constants, types and address helper for the mesh vertex indexer.
`default_nettype none
package mvdi_pkg;

   // image and vertex store dimensions
   localparam int IMG_WIDTH    = 640;
   localparam int IMG_HEIGHT   = 480;
   localparam int MAX_VERTICES = 32768;

   localparam int NUM_CORNERS = 3;
   localparam int X_W         = 10;
   localparam int Y_W         = 9;
   localparam int IDX_W       = 15;
   localparam int KIND_W      = 2;
   // wide enough for any image dimension in range, for the bounds compare
   localparam int DIM_W       = 13;

   localparam int MAP_DEPTH = IMG_WIDTH * IMG_HEIGHT;
   localparam int MAP_AW    = $clog2(MAP_DEPTH);
   // map entries hold index+1, zero meaning empty; also the vertex count width
   localparam int VCNT_W    = $clog2(MAX_VERTICES + 1);
   localparam int SEL_W     = $clog2(NUM_CORNERS);

   typedef enum logic [KIND_W-1:0] {
      KIND_VERTEX   = 2'd0,
      KIND_TRIANGLE = 2'd1,
      KIND_OVERFLOW = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_EMIT,
      ST_TRI
   } state_type;

   function automatic logic [MAP_AW-1:0] map_addr(input logic [X_W-1:0] x,
                                                 input logic [Y_W-1:0] y);
      return MAP_AW'(y) * MAP_AW'(IMG_WIDTH) + MAP_AW'(x);
   endfunction

endpackage
`default_nettype wire

// File: hdl/mvdi_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none
module mvdi_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule
`default_nettype wire

// File: hdl/mesh_vertex_dedup_indexer.sv
// Top level: triangle corner de-duplication against a per-pixel vertex index map.
`default_nettype none
// After reset the block sweeps the pixel map to empty, one entry a cycle;
// busy stays high until it is done. A triangle is taken when start is high
// and busy low. A triangle with two equal corners or a corner off the image
// is dropped in its accept cycle and busy never rises. Otherwise the three
// corners are read one per cycle through the single port of the map, then
// checked; if the vertex store would overflow, one overflow beat is given.
// Else each corner not yet in the map gets its write-back and new-vertex beat
// in turn, then the triangle beat follows. Beats appear on the rsp_ ports for
// one cycle, flagged by rsp_strobe, and must be taken as they come; rsp_last
// marks the final beat of a triangle.
module mesh_vertex_dedup_indexer (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [mvdi_pkg::X_W-1:0]      req_corner0_x,
   input  wire logic [mvdi_pkg::Y_W-1:0]      req_corner0_y,
   input  wire logic [mvdi_pkg::X_W-1:0]      req_corner1_x,
   input  wire logic [mvdi_pkg::Y_W-1:0]      req_corner1_y,
   input  wire logic [mvdi_pkg::X_W-1:0]      req_corner2_x,
   input  wire logic [mvdi_pkg::Y_W-1:0]      req_corner2_y,
   output logic                               rsp_strobe,
   output logic      [mvdi_pkg::KIND_W-1:0]   rsp_result_kind,
   output logic      [mvdi_pkg::IDX_W-1:0]    rsp_vertex_index,
   output logic      [mvdi_pkg::X_W-1:0]      rsp_vertex_pixel_x,
   output logic      [mvdi_pkg::Y_W-1:0]      rsp_vertex_pixel_y,
   output logic      [mvdi_pkg::IDX_W-1:0]    rsp_index_a,
   output logic      [mvdi_pkg::IDX_W-1:0]    rsp_index_b,
   output logic      [mvdi_pkg::IDX_W-1:0]    rsp_index_c,
   output logic                               rsp_last
);

   localparam int NC = mvdi_pkg::NUM_CORNERS;

   mvdi_pkg::state_type state_ff, state_in;

   logic [mvdi_pkg::MAP_AW-1:0] clr_ff, clr_in;
   logic [mvdi_pkg::SEL_W-1:0]  sel_ff, sel_in;
   logic [mvdi_pkg::VCNT_W-1:0] vcount_ff, vcount_in;

   logic [mvdi_pkg::X_W-1:0]    cx_ff [NC];
   logic [mvdi_pkg::X_W-1:0]    cx_in [NC];
   logic [mvdi_pkg::Y_W-1:0]    cy_ff [NC];
   logic [mvdi_pkg::Y_W-1:0]    cy_in [NC];
   logic [mvdi_pkg::MAP_AW-1:0] addr_ff [NC];
   logic [mvdi_pkg::MAP_AW-1:0] addr_in [NC];
   logic [mvdi_pkg::VCNT_W-1:0] entry_ff [NC];
   logic [mvdi_pkg::VCNT_W-1:0] entry_in [NC];
   logic [mvdi_pkg::IDX_W-1:0]  tri_ff [NC];
   logic [mvdi_pkg::IDX_W-1:0]  tri_in [NC];
   logic [NC-1:0]               fresh_ff, fresh_in;

   logic                          strobe_ff, strobe_in;
   logic [mvdi_pkg::KIND_W-1:0]   kind_ff, kind_in;
   logic [mvdi_pkg::IDX_W-1:0]    vidx_ff, vidx_in;
   logic [mvdi_pkg::X_W-1:0]      vpx_ff, vpx_in;
   logic [mvdi_pkg::Y_W-1:0]      vpy_ff, vpy_in;
   logic [mvdi_pkg::IDX_W-1:0]    ia_ff, ia_in;
   logic [mvdi_pkg::IDX_W-1:0]    ib_ff, ib_in;
   logic [mvdi_pkg::IDX_W-1:0]    ic_ff, ic_in;
   logic                          last_ff, last_in;

   logic                          ram_we;
   logic [mvdi_pkg::MAP_AW-1:0]   ram_addr;
   logic [mvdi_pkg::VCNT_W-1:0]   ram_wdata;
   logic [mvdi_pkg::VCNT_W-1:0]   ram_rdata;

   logic                          degenerate;
   logic                          off_image;
   logic [NC-1:0]                 fresh_now;
   logic [1:0]                    needed;
   logic [mvdi_pkg::VCNT_W:0]     total;

   mvdi_ram #(
      .WIDTH(mvdi_pkg::VCNT_W),
      .DEPTH(mvdi_pkg::MAP_DEPTH)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign degenerate =
      (req_corner0_x == req_corner1_x && req_corner0_y == req_corner1_y) ||
      (req_corner1_x == req_corner2_x && req_corner1_y == req_corner2_y) ||
      (req_corner0_x == req_corner2_x && req_corner0_y == req_corner2_y);

   assign off_image =
      (mvdi_pkg::DIM_W'(req_corner0_x) >= mvdi_pkg::DIM_W'(mvdi_pkg::IMG_WIDTH))  ||
      (mvdi_pkg::DIM_W'(req_corner1_x) >= mvdi_pkg::DIM_W'(mvdi_pkg::IMG_WIDTH))  ||
      (mvdi_pkg::DIM_W'(req_corner2_x) >= mvdi_pkg::DIM_W'(mvdi_pkg::IMG_WIDTH))  ||
      (mvdi_pkg::DIM_W'(req_corner0_y) >= mvdi_pkg::DIM_W'(mvdi_pkg::IMG_HEIGHT)) ||
      (mvdi_pkg::DIM_W'(req_corner1_y) >= mvdi_pkg::DIM_W'(mvdi_pkg::IMG_HEIGHT)) ||
      (mvdi_pkg::DIM_W'(req_corner2_y) >= mvdi_pkg::DIM_W'(mvdi_pkg::IMG_HEIGHT));

   // last corner's entry arrives straight from the RAM in the check cycle
   assign fresh_now = {ram_rdata == '0, entry_ff[1] == '0, entry_ff[0] == '0};
   assign needed    = {1'b0, fresh_now[0]} + {1'b0, fresh_now[1]} + {1'b0, fresh_now[2]};
   assign total     = {1'b0, vcount_ff} + (mvdi_pkg::VCNT_W + 1)'(needed);

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      sel_in    = sel_ff;
      vcount_in = vcount_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      addr_in   = addr_ff;
      entry_in  = entry_ff;
      tri_in    = tri_ff;
      fresh_in  = fresh_ff;

      strobe_in = 1'b0;
      kind_in   = kind_ff;
      vidx_in   = vidx_ff;
      vpx_in    = vpx_ff;
      vpy_in    = vpy_ff;
      ia_in     = ia_ff;
      ib_in     = ib_ff;
      ic_in     = ic_ff;
      last_in   = last_ff;

      ram_we    = 1'b0;
      ram_addr  = mvdi_pkg::map_addr(cx_ff[sel_ff], cy_ff[sel_ff]);
      ram_wdata = '0;

      unique case (state_ff)
         mvdi_pkg::ST_CLEAR: begin
            ram_we   = 1'b1;
            ram_addr = clr_ff;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == mvdi_pkg::MAP_AW'(mvdi_pkg::MAP_DEPTH - 1)) begin
               state_in = mvdi_pkg::ST_IDLE;
            end
         end

         mvdi_pkg::ST_IDLE: begin
            if (start && !degenerate && !off_image) begin
               cx_in[0] = req_corner0_x;
               cy_in[0] = req_corner0_y;
               cx_in[1] = req_corner1_x;
               cy_in[1] = req_corner1_y;
               cx_in[2] = req_corner2_x;
               cy_in[2] = req_corner2_y;
               sel_in   = '0;
               state_in = mvdi_pkg::ST_READ;
            end
         end

         mvdi_pkg::ST_READ: begin
            // issue one corner read a cycle; the previous corner's entry lands now
            addr_in[sel_ff] = ram_addr;
            if (sel_ff != '0) begin
               entry_in[sel_ff - 1'b1] = ram_rdata;
            end
            if (sel_ff == mvdi_pkg::SEL_W'(NC - 1)) begin
               state_in = mvdi_pkg::ST_EVAL;
            end else begin
               sel_in = sel_ff + 1'b1;
            end
         end

         mvdi_pkg::ST_EVAL: begin
            entry_in[2] = ram_rdata;
            fresh_in    = fresh_now;
            if (total > (mvdi_pkg::VCNT_W + 1)'(mvdi_pkg::MAX_VERTICES)) begin
               strobe_in = 1'b1;
               kind_in   = mvdi_pkg::KIND_OVERFLOW;
               vidx_in   = '0;
               vpx_in    = '0;
               vpy_in    = '0;
               ia_in     = '0;
               ib_in     = '0;
               ic_in     = '0;
               last_in   = 1'b1;
               state_in  = mvdi_pkg::ST_IDLE;
            end else begin
               sel_in   = '0;
               state_in = mvdi_pkg::ST_EMIT;
            end
         end

         mvdi_pkg::ST_EMIT: begin
            if (fresh_ff[sel_ff]) begin
               ram_we         = 1'b1;
               ram_addr       = addr_ff[sel_ff];
               ram_wdata      = vcount_ff + 1'b1;
               tri_in[sel_ff] = mvdi_pkg::IDX_W'(vcount_ff);
               vcount_in      = vcount_ff + 1'b1;
               strobe_in      = 1'b1;
               kind_in        = mvdi_pkg::KIND_VERTEX;
               vidx_in        = mvdi_pkg::IDX_W'(vcount_ff);
               vpx_in         = cx_ff[sel_ff];
               vpy_in         = cy_ff[sel_ff];
               ia_in          = '0;
               ib_in          = '0;
               ic_in          = '0;
               last_in        = 1'b0;
            end else begin
               tri_in[sel_ff] = mvdi_pkg::IDX_W'(entry_ff[sel_ff] - 1'b1);
            end
            if (sel_ff == mvdi_pkg::SEL_W'(NC - 1)) begin
               state_in = mvdi_pkg::ST_TRI;
            end else begin
               sel_in = sel_ff + 1'b1;
            end
         end

         mvdi_pkg::ST_TRI: begin
            strobe_in = 1'b1;
            kind_in   = mvdi_pkg::KIND_TRIANGLE;
            vidx_in   = '0;
            vpx_in    = '0;
            vpy_in    = '0;
            ia_in     = tri_ff[0];
            ib_in     = tri_ff[1];
            ic_in     = tri_ff[2];
            last_in   = 1'b1;
            state_in  = mvdi_pkg::ST_IDLE;
         end

         default: begin
            state_in = mvdi_pkg::ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mvdi_pkg::ST_CLEAR;
         clr_ff    <= '0;
         sel_ff    <= '0;
         vcount_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         sel_ff    <= sel_in;
         vcount_ff <= vcount_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      addr_ff  <= addr_in;
      entry_ff <= entry_in;
      tri_ff   <= tri_in;
      fresh_ff <= fresh_in;
      kind_ff  <= kind_in;
      vidx_ff  <= vidx_in;
      vpx_ff   <= vpx_in;
      vpy_ff   <= vpy_in;
      ia_ff    <= ia_in;
      ib_ff    <= ib_in;
      ic_ff    <= ic_in;
      last_ff  <= last_in;
   end

   assign busy               = (state_ff != mvdi_pkg::ST_IDLE);
   assign rsp_strobe         = strobe_ff;
   assign rsp_result_kind    = kind_ff;
   assign rsp_vertex_index   = vidx_ff;
   assign rsp_vertex_pixel_x = vpx_ff;
   assign rsp_vertex_pixel_y = vpy_ff;
   assign rsp_index_a        = ia_ff;
   assign rsp_index_b        = ib_ff;
   assign rsp_index_c        = ic_ff;
   assign rsp_last           = last_ff;

endmodule
`default_nettype wire
